[src/flow_statistics_table_core_macros.svh]
// Assertion helpers for the checker of the flow statistics table.
`ifndef FLOW_STATISTICS_TABLE_CORE_MACROS_SVH
`define FLOW_STATISTICS_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fst assertion failed");

// Next-cycle implication.
`define FST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fst assertion failed");

`endif

[src/fst_pkg.sv]
package fst_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int KEY_W         = 104;
	localparam int DIV_STEPS     = 4;
	localparam int STEP_W        = $clog2(DIV_STEPS);
	localparam int RAND_W        = 28;

	localparam logic [9:0] NS_PER_US = 10'd1000;
	localparam logic [6:0] RAND_MOD  = 7'd101;
	localparam logic [6:0] RATE_MAX  = 7'd100;

	// reciprocals: floor(x * RECIP >> SHIFT) is exact for 26-bit numerators
	// over 1000 and for 28-bit numerators over 101
	localparam logic [26:0] US_RECIP   = 27'd68719477;
	localparam int          US_SHIFT   = 36;
	localparam logic [28:0] RAND_RECIP = 29'd340195430;
	localparam int          RAND_SHIFT = 35;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic CFG_SAMPLING = 1'b0;
	localparam logic CFG_RATE     = 1'b1;

	typedef enum logic [2:0] {
		OUT_NOT_RECORDED = 3'd0,
		OUT_SAMPLED      = 3'd1,
		OUT_OTHER_PROTO  = 3'd2,
		OUT_NEW          = 3'd3,
		OUT_UPDATED      = 3'd4,
		OUT_FULL         = 3'd5
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DECIDE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [7:0]  protocol;
		logic [15:0] frame_len;
		logic [63:0] timestamp_ns;
		logic [7:0]  cpu_number;
		logic        fwd_dir;
		logic [5:0]  tcp_flags;
		logic        is_ipv4;
		logic        l4_present;
	} desc_t;

	typedef struct packed {
		logic        verdict;
		outcome_t    outcome;
		logic [31:0] flow_packets;
		logic [63:0] flow_bytes;
		logic [63:0] flow_duration_us;
	} result_t;

	typedef struct packed {
		logic accept;
		logic div_run;
		logic scan_run;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic record;
		logic scan_hit;
		logic scan_miss;
	} status_t;

endpackage

[src/fst_desc_if.sv]
interface fst_desc_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] l4_src;
	logic [15:0] l4_dst;
	logic [7:0]  protocol;
	logic [15:0] frame_len;
	logic [63:0] timestamp_ns;
	logic [7:0]  cpu_number;
	logic        fwd_dir;
	logic [5:0]  tcp_flags;
	logic        is_ipv4;
	logic        l4_present;

	modport source (output valid, src_ip, dst_ip, l4_src, l4_dst, protocol,
		frame_len, timestamp_ns, cpu_number, fwd_dir, tcp_flags, is_ipv4,
		l4_present, input ready);
	modport sink (input valid, src_ip, dst_ip, l4_src, l4_dst, protocol,
		frame_len, timestamp_ns, cpu_number, fwd_dir, tcp_flags, is_ipv4,
		l4_present, output ready);
endinterface

[src/fst_result_if.sv]
interface fst_result_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic [2:0]  outcome;
	logic [31:0] flow_packets;
	logic [63:0] flow_bytes;
	logic [63:0] flow_duration_us;

	modport source (output valid, verdict, outcome, flow_packets, flow_bytes,
		flow_duration_us, input ready);
	modport sink (input valid, verdict, outcome, flow_packets, flow_bytes,
		flow_duration_us, output ready);
endinterface

[src/fst_ctrl.sv]
module fst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  fst_pkg::status_t status,
	output fst_pkg::cmd_t    cmd
);

	fst_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fst_pkg::ST_IDLE: begin
				if (in_valid) state_d = fst_pkg::ST_DIVIDE;
			end
			fst_pkg::ST_DIVIDE: begin
				if (status.div_done) state_d = fst_pkg::ST_DECIDE;
			end
			fst_pkg::ST_DECIDE: begin
				state_d = status.record ? fst_pkg::ST_SCAN : fst_pkg::ST_COMMIT;
			end
			fst_pkg::ST_SCAN: begin
				if (status.scan_hit || status.scan_miss) state_d = fst_pkg::ST_COMMIT;
			end
			fst_pkg::ST_COMMIT: begin
				if (out_free) state_d = fst_pkg::ST_IDLE;
			end
			default: state_d = fst_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == fst_pkg::ST_IDLE);
		cmd.accept   = (state_q == fst_pkg::ST_IDLE) && in_valid;
		cmd.div_run  = (state_q == fst_pkg::ST_DIVIDE);
		cmd.scan_run = (state_q == fst_pkg::ST_SCAN);
		cmd.commit   = (state_q == fst_pkg::ST_COMMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fst_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

[src/fst_datapath.sv]
module fst_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [6:0]       cfg_data,
	input  fst_pkg::desc_t   desc,
	input  fst_pkg::cmd_t    cmd,
	output fst_pkg::status_t status,
	output fst_pkg::result_t result
);

	logic sampling_q;
	logic [6:0] rate_q;

	fst_pkg::desc_t desc_q;

	// timestamp by 1000: long division one 16-bit digit a step, each digit
	// quotient from a reciprocal multiply; sampling value mod 101 alongside
	logic [fst_pkg::STEP_W-1:0] step_q;
	logic [63:0] quot_q;
	logic [9:0]  rem_us_q;
	logic [25:0] us_num;
	logic [52:0] us_prod;
	logic [15:0] us_digit;
	logic [25:0] us_back;
	logic [fst_pkg::RAND_W-1:0] rnd_q;
	logic [21:0] rnd_quo_q;
	logic [56:0] rnd_prod;
	logic [fst_pkg::RAND_W-1:0] rnd_back;
	logic [6:0]  rem_rnd_q;

	logic [fst_pkg::CNT_W-1:0] count_q;
	logic [fst_pkg::CNT_W-1:0] scan_idx_q;
	logic                      rd_pend_s1;
	logic [fst_pkg::IDX_W-1:0] rd_idx_s1;
	logic                      found_q;
	logic [fst_pkg::IDX_W-1:0] hit_idx_q;
	logic [31:0]               hit_pkts_q;
	logic [63:0]               hit_bytes_q;
	logic [63:0]               hit_first_q;

	// per-entry stores; entries fill from index zero and are never freed,
	// so the fill count doubles as the valid map
	logic [fst_pkg::KEY_W-1:0] key_mem   [fst_pkg::TABLE_ENTRIES];
	logic [31:0]               pkts_mem  [fst_pkg::TABLE_ENTRIES];
	logic [63:0]               bytes_mem [fst_pkg::TABLE_ENTRIES];
	logic [63:0]               first_mem [fst_pkg::TABLE_ENTRIES];
	logic [fst_pkg::KEY_W-1:0] key_rd_s1;
	logic [31:0]               pkts_rd_s1;
	logic [63:0]               bytes_rd_s1;
	logic [63:0]               first_rd_s1;

	logic [fst_pkg::KEY_W-1:0] key;
	logic [15:0]               sport, dport;
	logic                      is_icmp, proto_ok, drop;
	fst_pkg::outcome_t         cls;
	logic                      issue, match, full;
	logic                      mem_we;
	logic [fst_pkg::IDX_W-1:0] mem_wa;
	logic [31:0]               new_pkts;
	logic [63:0]               new_bytes, new_first, new_dur;
	fst_pkg::result_t          res_d;
	fst_pkg::result_t          result_q;

	assign us_num   = {rem_us_q, quot_q[63:48]};
	assign us_prod  = 53'(us_num) * 53'(fst_pkg::US_RECIP);
	assign us_digit = us_prod[fst_pkg::US_SHIFT+15:fst_pkg::US_SHIFT];
	assign us_back  = 26'(us_digit) * 26'(fst_pkg::NS_PER_US);
	assign rnd_prod = 57'(rnd_q) * 57'(fst_pkg::RAND_RECIP);
	assign rnd_back = fst_pkg::RAND_W'(rnd_quo_q) * fst_pkg::RAND_W'(fst_pkg::RAND_MOD);

	assign is_icmp  = (desc_q.protocol == fst_pkg::PROTO_ICMP);
	assign proto_ok = is_icmp || (desc_q.protocol == fst_pkg::PROTO_TCP)
		|| (desc_q.protocol == fst_pkg::PROTO_UDP);
	assign drop     = sampling_q && (rem_rnd_q > rate_q);
	assign sport    = is_icmp ? 16'd0 : desc_q.l4_src;
	assign dport    = is_icmp ? 16'd0 : desc_q.l4_dst;
	assign key      = {desc_q.src_ip, desc_q.dst_ip, sport, dport, desc_q.protocol};

	always_comb begin
		if (!desc_q.is_ipv4) cls = fst_pkg::OUT_NOT_RECORDED;
		else if (drop) cls = fst_pkg::OUT_SAMPLED;
		else if (!proto_ok) cls = fst_pkg::OUT_OTHER_PROTO;
		else if (!desc_q.l4_present) cls = fst_pkg::OUT_NOT_RECORDED;
		else cls = fst_pkg::OUT_NEW;
	end

	assign match = cmd.scan_run && rd_pend_s1 && (key_rd_s1 == key);
	assign issue = cmd.scan_run && !found_q && !match && (scan_idx_q < count_q);
	assign full  = (count_q == fst_pkg::CNT_W'(fst_pkg::TABLE_ENTRIES));

	assign status.div_done  = cmd.div_run
		&& (step_q == fst_pkg::STEP_W'(fst_pkg::DIV_STEPS - 1));
	assign status.record    = (cls == fst_pkg::OUT_NEW);
	assign status.scan_hit  = match;
	assign status.scan_miss = cmd.scan_run && !found_q && !rd_pend_s1
		&& (scan_idx_q >= count_q);

	always_comb begin
		new_pkts  = hit_pkts_q + 32'd1;
		new_bytes = hit_bytes_q + {48'd0, desc_q.frame_len};
		new_first = hit_first_q;
		new_dur   = quot_q - hit_first_q;
		mem_wa    = hit_idx_q;
		mem_we    = 1'b0;
		res_d     = '{verdict: 1'b0, outcome: cls, flow_packets: 32'd0,
			flow_bytes: 64'd0, flow_duration_us: 64'd0};
		if (cls == fst_pkg::OUT_SAMPLED) res_d.verdict = 1'b1;
		if (status.record) begin
			if (found_q) begin
				mem_we        = 1'b1;
				res_d.outcome = fst_pkg::OUT_UPDATED;
			end else if (!full) begin
				mem_we    = 1'b1;
				mem_wa    = count_q[fst_pkg::IDX_W-1:0];
				new_pkts  = 32'd1;
				new_bytes = {48'd0, desc_q.frame_len};
				new_first = quot_q;
				new_dur   = 64'd0;
				res_d.outcome = fst_pkg::OUT_NEW;
			end else begin
				res_d.outcome = fst_pkg::OUT_FULL;
			end
			if (mem_we) begin
				res_d.flow_packets     = new_pkts;
				res_d.flow_bytes       = new_bytes;
				res_d.flow_duration_us = new_dur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampling_q <= 1'b0;
			rate_q     <= fst_pkg::RATE_MAX;
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
			step_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fst_pkg::CFG_SAMPLING: sampling_q <= cfg_data[0];
					fst_pkg::CFG_RATE: rate_q <= (cfg_data > fst_pkg::RATE_MAX)
						? fst_pkg::RATE_MAX : cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				step_q     <= '0;
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end
			if (cmd.div_run) step_q <= step_q + 1'b1;
			rd_pend_s1 <= issue;
			if (issue) scan_idx_q <= scan_idx_q + 1'b1;
			if (match) found_q <= 1'b1;
			if (cmd.commit && mem_we && !found_q) count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			desc_q    <= desc;
			quot_q    <= desc.timestamp_ns;
			rem_us_q  <= '0;
			rnd_q     <= desc.timestamp_ns[fst_pkg::RAND_W-1:0]
				^ {{(fst_pkg::RAND_W-8){1'b0}}, desc.cpu_number};
			rem_rnd_q <= '0;
		end else if (cmd.div_run) begin
			quot_q   <= {quot_q[47:0], us_digit};
			rem_us_q <= 10'(us_num - us_back);
			// sampling value: quotient on the first step, remainder on the next
			if (step_q == '0)
				rnd_quo_q <= rnd_prod[fst_pkg::RAND_SHIFT+21:fst_pkg::RAND_SHIFT];
			if (step_q == fst_pkg::STEP_W'(1)) rem_rnd_q <= 7'(rnd_q - rnd_back);
		end
		rd_idx_s1 <= scan_idx_q[fst_pkg::IDX_W-1:0];
		if (match) begin
			hit_idx_q   <= rd_idx_s1;
			hit_pkts_q  <= pkts_rd_s1;
			hit_bytes_q <= bytes_rd_s1;
			hit_first_q <= first_rd_s1;
		end
		if (cmd.commit) result_q <= res_d;
	end

	always_ff @(posedge clk) begin
		key_rd_s1   <= key_mem[scan_idx_q[fst_pkg::IDX_W-1:0]];
		pkts_rd_s1  <= pkts_mem[scan_idx_q[fst_pkg::IDX_W-1:0]];
		bytes_rd_s1 <= bytes_mem[scan_idx_q[fst_pkg::IDX_W-1:0]];
		first_rd_s1 <= first_mem[scan_idx_q[fst_pkg::IDX_W-1:0]];
		if (cmd.commit && mem_we) begin
			key_mem[mem_wa]   <= key;
			pkts_mem[mem_wa]  <= new_pkts;
			bytes_mem[mem_wa] <= new_bytes;
			first_mem[mem_wa] <= new_first;
		end
	end

	assign result = result_q;

endmodule

[src/flow_statistics_table_core.sv]
// channel   | dir | beat
// ----------+-----+-----------------------------------------------
// desc      | in  | one parsed packet descriptor
// result    | out | verdict, outcome and flow counters after it
// cfg_*     | in  | register write, index 0 sampling, 1 rate
//
// An item that skips the table runs from accept through 4 divider steps (timestamp
// to microseconds one 16-bit digit a step, sampling remainder alongside), a decide
// state and a commit state before the next accept. A lookup adds a scan state that
// reads the stored flows in order until a key matches or all have been read.
// Reset empties the table at once. desc is taken only when idle; a finished
// result waits in its output register and stalls only the commit.
module flow_statistics_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [6:0]   cfg_data,
	fst_desc_if.sink     desc,
	fst_result_if.source result
);

	fst_pkg::cmd_t    cmd;
	fst_pkg::status_t status;
	fst_pkg::desc_t   desc_bus;
	fst_pkg::result_t res;

	assign desc_bus = '{src_ip: desc.src_ip, dst_ip: desc.dst_ip,
		l4_src: desc.l4_src, l4_dst: desc.l4_dst, protocol: desc.protocol,
		frame_len: desc.frame_len, timestamp_ns: desc.timestamp_ns,
		cpu_number: desc.cpu_number, fwd_dir: desc.fwd_dir,
		tcp_flags: desc.tcp_flags, is_ipv4: desc.is_ipv4, l4_present: desc.l4_present};

	fst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (desc.valid),
		.in_ready  (desc.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	fst_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.desc      (desc_bus),
		.cmd       (cmd),
		.status    (status),
		.result    (res)
	);

	assign result.verdict          = res.verdict;
	assign result.outcome          = res.outcome;
	assign result.flow_packets     = res.flow_packets;
	assign result.flow_bytes       = res.flow_bytes;
	assign result.flow_duration_us = res.flow_duration_us;

endmodule

[src/fst_checker.sv]
`include "flow_statistics_table_core_macros.svh"

module fst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        verdict,
	input logic [2:0]  outcome,
	input logic [31:0] flow_packets,
	input logic [63:0] flow_bytes,
	input logic [63:0] flow_duration_us
);

	`FST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`FST_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`FST_ASSERT_NOW(a_drop_sampled, out_valid && verdict, outcome == 3'(fst_pkg::OUT_SAMPLED))
	`FST_ASSERT_NOW(a_new_flow, out_valid && outcome == 3'(fst_pkg::OUT_NEW), flow_packets == 32'd1 && flow_duration_us == 64'd0)
	`FST_ASSERT_NOW(a_no_counts, out_valid && outcome != 3'(fst_pkg::OUT_NEW) && outcome != 3'(fst_pkg::OUT_UPDATED), flow_packets == 32'd0 && flow_bytes == 64'd0 && flow_duration_us == 64'd0)

endmodule

bind flow_statistics_table_core fst_checker u_fst_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (desc.valid),
	.in_ready         (desc.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.verdict          (result.verdict),
	.outcome          (result.outcome),
	.flow_packets     (result.flow_packets),
	.flow_bytes       (result.flow_bytes),
	.flow_duration_us (result.flow_duration_us)
);
